>>> rtl/ifh_pkg.sv
package ifh_pkg;

  localparam logic [63:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [63:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [63:0] SipC3 = 64'h7465646279746573;
  // message length 16 sits in the top byte of the final block
  localparam logic [63:0] SipTail = {8'd16, 56'd0};
  localparam logic [63:0] SipFinXor = 64'h00000000000000ff;

  localparam logic [31:0] JhGolden = 32'hdeadbeef;
  localparam logic [31:0] JhLen3 = 32'd12;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegEhashSecret = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNamespaceMix = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSipKeyLow = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSipKeyHigh = 2'd3;

  typedef struct packed {
    logic [63:0] v3;
    logic [63:0] v2;
    logic [63:0] v1;
    logic [63:0] v0;
  } sip_state_t;

  // fields that ride along the siphash stages untouched
  typedef struct packed {
    logic [31:0] lword;
    logic [31:0] ports;
  } flow_side_t;

  function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned s);
    rotl64 = (x << s) | (x >> (64 - s));
  endfunction

  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned s);
    rotl32 = (x << s) | (x >> (32 - s));
  endfunction

  function automatic sip_state_t sip_round(sip_state_t vi);
    sip_state_t v;
    v = vi;
    v.v0 = v.v0 + v.v1; v.v1 = rotl64(v.v1, 13); v.v1 = v.v1 ^ v.v0;
    v.v0 = rotl64(v.v0, 32);
    v.v2 = v.v2 + v.v3; v.v3 = rotl64(v.v3, 16); v.v3 = v.v3 ^ v.v2;
    v.v0 = v.v0 + v.v3; v.v3 = rotl64(v.v3, 21); v.v3 = v.v3 ^ v.v0;
    v.v2 = v.v2 + v.v1; v.v1 = rotl64(v.v1, 17); v.v1 = v.v1 ^ v.v2;
    v.v2 = rotl64(v.v2, 32);
    return v;
  endfunction

  // one jhash final-mix step: x ^= y; x -= rol(y, s)
  function automatic logic [31:0] jh_mix(logic [31:0] x, logic [31:0] y, int unsigned s);
    jh_mix = (x ^ y) - rotl32(y, s);
  endfunction

endpackage

>>> rtl/ifh_sip_pipe.sv
module ifh_sip_pipe (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [63:0]             key_low_i,
  input  logic [63:0]             key_high_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [127:0]            in_words_i,
  input  ifh_pkg::flow_side_t     in_side_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [31:0]             out_fhash_o,
  output ifh_pkg::flow_side_t     out_side_o
);

  localparam int unsigned NStg = 6;

  logic [NStg-1:0]        vld_q;
  logic [NStg-1:0]        adv;
  ifh_pkg::sip_state_t    v_q [NStg-1];
  ifh_pkg::sip_state_t    v_d [NStg-1];
  ifh_pkg::flow_side_t    side_q [NStg];
  logic [63:0]            m1_q;
  logic [31:0]            fhash_q;
  logic [31:0]            fhash_d;

  // a stage takes a new word when it is empty or its content moves on
  assign adv[NStg-1] = !vld_q[NStg-1] || out_ready_i;
  for (genvar k = 0; k < NStg - 1; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end

  assign in_ready_o = adv[0];

  always_comb begin
    ifh_pkg::sip_state_t t;
    logic [63:0] m0;
    m0 = in_words_i[63:0];
    // key setup and first block
    t.v0 = ifh_pkg::SipC0 ^ key_low_i;
    t.v1 = ifh_pkg::SipC1 ^ key_high_i;
    t.v2 = ifh_pkg::SipC2 ^ key_low_i;
    t.v3 = ifh_pkg::SipC3 ^ key_high_i ^ m0;
    t = ifh_pkg::sip_round(t);
    t.v0 = t.v0 ^ m0;
    v_d[0] = t;
    // second block
    t = v_q[0];
    t.v3 = t.v3 ^ m1_q;
    t = ifh_pkg::sip_round(t);
    t.v0 = t.v0 ^ m1_q;
    v_d[1] = t;
    // length block and finalization marker
    t = v_q[1];
    t.v3 = t.v3 ^ ifh_pkg::SipTail;
    t = ifh_pkg::sip_round(t);
    t.v0 = t.v0 ^ ifh_pkg::SipTail;
    t.v2 = t.v2 ^ ifh_pkg::SipFinXor;
    v_d[2] = t;
    v_d[3] = ifh_pkg::sip_round(v_q[2]);
    v_d[4] = ifh_pkg::sip_round(v_q[3]);
    t = ifh_pkg::sip_round(v_q[4]);
    fhash_d = t.v0[31:0] ^ t.v1[31:0] ^ t.v2[31:0] ^ t.v3[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      v_q[0]    <= v_d[0];
      m1_q      <= in_words_i[127:64];
      side_q[0] <= in_side_i;
    end
    for (int k = 1; k < NStg - 1; k++) begin
      if (adv[k]) begin
        v_q[k]    <= v_d[k];
        side_q[k] <= side_q[k-1];
      end
    end
    if (adv[NStg-1]) begin
      fhash_q        <= fhash_d;
      side_q[NStg-1] <= side_q[NStg-2];
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign out_fhash_o = fhash_q;
  assign out_side_o  = side_q[NStg-1];

endmodule

>>> rtl/ifh_jhash_pipe.sv
module ifh_jhash_pipe (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [31:0]             seed_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [31:0]             in_fhash_i,
  input  ifh_pkg::flow_side_t     in_side_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [31:0]             out_hash_o
);

  logic [2:0]  vld_q;
  logic [2:0]  adv;
  logic [31:0] a1_q, b1_q, c1_q, a1_d, b1_d, c1_d;
  logic [31:0] a2_q, b2_q, c2_q, a2_d, b2_d, c2_d;
  logic [31:0] c3_q, c3_d;

  assign adv[2] = !vld_q[2] || out_ready_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_ready_o = adv[0];

  always_comb begin
    logic [31:0] a, b, c;
    a = in_side_i.lword + seed_i;
    b = in_fhash_i + seed_i;
    c = in_side_i.ports + seed_i;
    c1_d = ifh_pkg::jh_mix(c, b, 14);
    a1_d = ifh_pkg::jh_mix(a, c1_d, 11);
    b1_d = b;

    b2_d = ifh_pkg::jh_mix(b1_q, a1_q, 25);
    c2_d = ifh_pkg::jh_mix(c1_q, b2_d, 16);
    a2_d = ifh_pkg::jh_mix(a1_q, c2_d, 4);

    b = ifh_pkg::jh_mix(b2_q, a2_q, 14);
    c3_d = ifh_pkg::jh_mix(c2_q, b, 24);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a1_q <= a1_d;
      b1_q <= b1_d;
      c1_q <= c1_d;
    end
    if (adv[1]) begin
      a2_q <= a2_d;
      b2_q <= b2_d;
      c2_q <= c2_d;
    end
    if (adv[2]) begin
      c3_q <= c3_d;
    end
  end

  assign out_valid_o = vld_q[2];
  assign out_hash_o  = c3_q;

endmodule

>>> rtl/ipv6_flow_hash_unit.sv
// IPv6 flow hash: one connection tuple in, one 32-bit hash out. The four foreign
// address words go through keyed SipHash-1-3 (two message blocks, a length block,
// three finishing rounds, one round per pipeline stage), the low 32 bits of which
// are mixed with the local address word and the port word {local_port, foreign_port}
// by the three-word jhash final mix seeded with secret + namespace mix + 0xdeadbeef
// + 12. The pipeline is nine register stages deep and takes a new word every cycle
// when nothing stalls. Back pressure stops only the stages that are full, so bubbles
// are squeezed out. Write the configuration registers only while the pipeline is
// empty; the key and seed are sampled as words flow through.
module ipv6_flow_hash_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ifh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // local_addr_word, local_port, foreign_word0..3, foreign_port (lowest bit up)
  input  logic [191:0]                  s_axis_tdata,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // flow_hash
  output logic [31:0]                   m_axis_tdata
);

  logic [31:0] ehash_secret_q;
  logic [31:0] namespace_mix_q;
  logic [63:0] sip_key_low_q;
  logic [63:0] sip_key_high_q;
  logic [31:0] seed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ehash_secret_q  <= '0;
      namespace_mix_q <= '0;
      sip_key_low_q   <= '0;
      sip_key_high_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ifh_pkg::RegEhashSecret:  ehash_secret_q  <= cfg_wdata_i[31:0];
        ifh_pkg::RegNamespaceMix: namespace_mix_q <= cfg_wdata_i[31:0];
        ifh_pkg::RegSipKeyLow:    sip_key_low_q   <= cfg_wdata_i;
        ifh_pkg::RegSipKeyHigh:   sip_key_high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign seed = ehash_secret_q + namespace_mix_q + ifh_pkg::JhGolden + ifh_pkg::JhLen3;

  ifh_pkg::flow_side_t in_side;
  ifh_pkg::flow_side_t mid_side;
  logic                mid_valid;
  logic                mid_ready;
  logic [31:0]         mid_fhash;

  assign in_side.lword = s_axis_tdata[31:0];
  assign in_side.ports = {s_axis_tdata[47:32], s_axis_tdata[191:176]};

  ifh_sip_pipe u_sip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_low_i   (sip_key_low_q),
    .key_high_i  (sip_key_high_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_words_i  (s_axis_tdata[175:48]),
    .in_side_i   (in_side),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_fhash_o (mid_fhash),
    .out_side_o  (mid_side)
  );

  ifh_jhash_pipe u_jhash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_fhash_i  (mid_fhash),
    .in_side_i   (mid_side),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hash_o  (m_axis_tdata)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RunLimit = 200000;
  localparam int unsigned PipeDepth = 9;
  localparam int unsigned PhaseItems = 175;

  // last field in the low bits, so the struct maps straight onto tdata
  typedef struct packed {
    logic [15:0] fport;
    logic [31:0] fw3;
    logic [31:0] fw2;
    logic [31:0] fw1;
    logic [31:0] fw0;
    logic [15:0] lport;
    logic [31:0] lword;
  } flow_t;

  class flow_hash_checker;
    logic [31:0] secret;
    logic [31:0] ns_mix;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [63:0] sv [4];
    logic [31:0] pending_hashes [$];
    int unsigned errors;

    function new();
      secret = '0;
      ns_mix = '0;
      key_lo = '0;
      key_hi = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [ifh_pkg::CfgIdxW-1:0] idx, logic [63:0] data);
      case (idx)
        ifh_pkg::RegEhashSecret: secret = data[31:0];
        ifh_pkg::RegNamespaceMix: ns_mix = data[31:0];
        ifh_pkg::RegSipKeyLow: key_lo = data;
        ifh_pkg::RegSipKeyHigh: key_hi = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] rol64(logic [63:0] x, int unsigned s);
      return (x << s) | (x >> (64 - s));
    endfunction

    function logic [31:0] rol32(logic [31:0] x, int unsigned s);
      return (x << s) | (x >> (32 - s));
    endfunction

    function void sip_round();
      sv[0] = sv[0] + sv[1]; sv[1] = rol64(sv[1], 13) ^ sv[0]; sv[0] = rol64(sv[0], 32);
      sv[2] = sv[2] + sv[3]; sv[3] = rol64(sv[3], 16) ^ sv[2];
      sv[0] = sv[0] + sv[3]; sv[3] = rol64(sv[3], 21) ^ sv[0];
      sv[2] = sv[2] + sv[1]; sv[1] = rol64(sv[1], 17) ^ sv[2]; sv[2] = rol64(sv[2], 32);
    endfunction

    function void sip_absorb(logic [63:0] m);
      sv[3] = sv[3] ^ m;
      sip_round();
      sv[0] = sv[0] ^ m;
    endfunction

    function logic [31:0] predict_flow_hash(flow_t f);
      logic [63:0] sip_out;
      logic [31:0] a, b, c, seed;
      sv[0] = ifh_pkg::SipC0 ^ key_lo;
      sv[1] = ifh_pkg::SipC1 ^ key_hi;
      sv[2] = ifh_pkg::SipC2 ^ key_lo;
      sv[3] = ifh_pkg::SipC3 ^ key_hi;
      sip_absorb({f.fw1, f.fw0});
      sip_absorb({f.fw3, f.fw2});
      sip_absorb(ifh_pkg::SipTail);
      sv[2] = sv[2] ^ ifh_pkg::SipFinXor;
      for (int r = 0; r < 3; r++) sip_round();
      sip_out = sv[0] ^ sv[1] ^ sv[2] ^ sv[3];
      // seed wraps mod 2^32
      seed = secret + ns_mix + ifh_pkg::JhGolden + ifh_pkg::JhLen3;
      a = f.lword + seed;
      b = sip_out[31:0] + seed;
      c = {f.lport, f.fport} + seed;
      c = (c ^ b) - rol32(b, 14);
      a = (a ^ c) - rol32(c, 11);
      b = (b ^ a) - rol32(a, 25);
      c = (c ^ b) - rol32(b, 16);
      a = (a ^ c) - rol32(c, 4);
      b = (b ^ a) - rol32(a, 14);
      c = (c ^ b) - rol32(b, 24);
      return c;
    endfunction

    function void note_flow(flow_t f);
      pending_hashes.push_back(predict_flow_hash(f));
    endfunction

    task report_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task check_hash(logic [31:0] got);
      logic [31:0] want;
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %h with no word outstanding", got));
      end else begin
        want = pending_hashes.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("flow_hash %h, expected %h", got, want));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ifh_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  flow_hash_checker book = new();
  int unsigned src_idle_pct = 11;
  int unsigned dst_idle_pct = 49;
  int unsigned rx_hold = 0;
  int unsigned cycle_count = 0;

  ipv6_flow_hash_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when rx_hold is loaded
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) book.check_hash(m_axis_tdata);
    end
  end

  // returns at the accepting edge; caller must follow with send_flow or drain
  task automatic send_flow(input flow_t f);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_flow(f);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (book.pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ifh_pkg::CfgIdxW-1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    book.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    flow_t f;
    logic [31:0] w;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words, first at reset settings, then with every register at max
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain();
        // upper bits of the 32-bit registers must be dropped
        write_reg(ifh_pkg::RegEhashSecret, '1);
        write_reg(ifh_pkg::RegNamespaceMix, '1);
        write_reg(ifh_pkg::RegSipKeyLow, '1);
        write_reg(ifh_pkg::RegSipKeyHigh, '1);
      end
      for (int k = 0; k < 12; k++) begin
        f = '0;
        case (k)
          1: f = '1;
          2: f.lword = '1;
          3: f.lport = '1;
          4: f.fw0 = '1;
          5: f.fw1 = '1;
          6: f.fw2 = '1;
          7: f.fw3 = '1;
          8: f.fport = '1;
          9: f = {6{32'haaaaaaaa}};
          10: f = {6{32'h55555555}};
          11: begin
            f.lport = 16'h8000;
            f.fport = 16'h0001;
            f.lword = 32'h80000001;
          end
          default: ;
        endcase
        send_flow(f);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase / 2)
        0: begin src_idle_pct = 11; dst_idle_pct = 49; end
        1: begin src_idle_pct = 49; dst_idle_pct = 11; end
        default: begin src_idle_pct = 0; dst_idle_pct = 0; end
      endcase
      if (phase == 3) begin
        write_reg(ifh_pkg::RegEhashSecret, 64'hffffffff);
        write_reg(ifh_pkg::RegNamespaceMix, {$urandom, $urandom});
        write_reg(ifh_pkg::RegSipKeyLow, '0);
        write_reg(ifh_pkg::RegSipKeyHigh, '1);
      end else begin
        write_reg(ifh_pkg::RegEhashSecret, {$urandom, $urandom});
        write_reg(ifh_pkg::RegNamespaceMix, {$urandom, $urandom});
        write_reg(ifh_pkg::RegSipKeyLow, {$urandom, $urandom});
        write_reg(ifh_pkg::RegSipKeyHigh, {$urandom, $urandom});
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // block fills up behind a long output stall
        if (phase == 4 && n == 30) rx_hold = 90;
        // pause input until everything in flight has come out
        if (phase == 2 && n == 80) drain();
        f.lword = pick_word();
        w = pick_word();
        f.lport = w[15:0];
        f.fw0 = pick_word();
        f.fw1 = pick_word();
        f.fw2 = pick_word();
        f.fw3 = pick_word();
        w = pick_word();
        f.fport = w[15:0];
        send_flow(f);
      end
    end

    drain();
    repeat (PipeDepth * 4) @(posedge clk_i);
    if (book.errors == 0 && book.pending_hashes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
